// ===== rtl/core/cmrb_pkg.sv =====
package cmrb_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned OFS_WIDTH  = 8;
   localparam int unsigned LEN_WIDTH  = 4;
   localparam int unsigned UNITS      = 4;

   // Four-bit strict booleans
   localparam logic [3:0] MB_TRUE  = 4'h6;
   localparam logic [3:0] MB_FALSE = 4'h9;
   localparam logic [3:0] NIBBLE_ALL = 4'hf;

   localparam logic [LEN_WIDTH-1:0] WORD_BYTES = 4'd4;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;

   localparam logic [1:0] RESP_OK    = 2'd0;
   localparam logic [1:0] RESP_BURST = 2'd1;
   localparam logic [1:0] RESP_CMD   = 2'd2;

   localparam logic [OFS_WIDTH-1:0] OFS_LOCK        = 8'h00;
   localparam logic [OFS_WIDTH-1:0] OFS_EXT_CTRL    = 8'h04;
   localparam logic [OFS_WIDTH-1:0] OFS_EXT_STATUS  = 8'h08;
   localparam logic [OFS_WIDTH-1:0] OFS_ENABLES     = 8'h0c;
   localparam logic [OFS_WIDTH-1:0] OFS_HINTS       = 8'h10;
   localparam logic [OFS_WIDTH-1:0] OFS_HINT_STATUS = 8'h14;

   typedef struct packed {
      logic [1:0]            kind;
      logic [OFS_WIDTH-1:0]  byte_offset;
      logic [LEN_WIDTH-1:0]  access_length;
      logic [DATA_WIDTH-1:0] write_value;
      logic                  debug_allowed;
      logic [UNITS-1:0]      idle_flags;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_value;
      logic [1:0]            response;
   } rsp_type;

endpackage

// ===== rtl/core/cmrb_csr.sv =====
module cmrb_csr
   import cmrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   logic [3:0] ext_select_ff, ext_select_in;
   logic [3:0] ext_high_speed_ff, ext_high_speed_in;
   logic [3:0] ext_ack_ff, ext_ack_in;
   logic       unlocked_ff, unlocked_in;
   logic [3:0] clock_enables_ff, clock_enables_in;
   logic [3:0] hint_bits_ff, hint_bits_in;
   logic [3:0] hint_status_ff, hint_status_in;

   logic       len_ok;
   logic       do_write;
   logic       now_ext;
   logic       want_ext;
   logic [3:0] wv_low;

   assign len_ok   = (req.access_length == WORD_BYTES);
   assign do_write = fire && len_ok && (req.kind == KIND_WRITE);
   assign wv_low   = req.write_value[3:0];
   assign now_ext  = (ext_select_ff == MB_TRUE);
   assign want_ext = (wv_low == MB_TRUE);

   always_comb begin
      rsp.read_value = '0;
      if (!len_ok) begin
         rsp.response = RESP_BURST;
      end else if (req.kind == KIND_READ) begin
         rsp.response = RESP_OK;
         case (req.byte_offset)
            OFS_LOCK:        rsp.read_value = {31'd0, unlocked_ff};
            OFS_EXT_CTRL:    rsp.read_value = {24'd0, ext_high_speed_ff, ext_select_ff};
            OFS_EXT_STATUS:  rsp.read_value = {28'd0, ext_ack_ff};
            OFS_ENABLES:     rsp.read_value = {28'd0, clock_enables_ff};
            OFS_HINTS:       rsp.read_value = {28'd0, hint_bits_ff};
            OFS_HINT_STATUS: rsp.read_value = {28'd0, hint_status_ff};
            default:         rsp.read_value = '0;
         endcase
      end else if (req.kind == KIND_WRITE) begin
         rsp.response = RESP_OK;
      end else begin
         rsp.response = RESP_CMD;
      end
   end

   always_comb begin
      ext_select_in     = ext_select_ff;
      ext_high_speed_in = ext_high_speed_ff;
      ext_ack_in        = ext_ack_ff;
      unlocked_in       = unlocked_ff;
      clock_enables_in  = clock_enables_ff;
      hint_bits_in      = hint_bits_ff;
      hint_status_in    = hint_status_ff;
      if (do_write) begin
         case (req.byte_offset)
            OFS_LOCK: begin
               if (!req.write_value[0]) begin
                  unlocked_in = 1'b0;
               end
            end
            OFS_EXT_CTRL: begin
               if (unlocked_ff && req.debug_allowed) begin
                  ext_high_speed_in = req.write_value[7:4];
                  // move only on a real transition of the strict flag
                  if (!now_ext && want_ext) begin
                     ext_select_in = MB_TRUE;
                     ext_ack_in    = MB_TRUE;
                  end else if (now_ext && !want_ext) begin
                     ext_select_in = MB_FALSE;
                     ext_ack_in    = MB_FALSE;
                  end
               end
            end
            OFS_ENABLES: clock_enables_in = wv_low;
            OFS_HINTS: begin
               hint_bits_in   = wv_low;
               // drop a status bit only where the hint is off and the unit idles
               hint_status_in = (hint_status_ff & ~(~wv_low & req.idle_flags)) | wv_low;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_select_ff     <= MB_FALSE;
         ext_high_speed_ff <= MB_FALSE;
         ext_ack_ff        <= MB_FALSE;
         unlocked_ff       <= 1'b1;
         clock_enables_ff  <= NIBBLE_ALL;
         hint_bits_ff      <= NIBBLE_ALL;
         hint_status_ff    <= NIBBLE_ALL;
      end else begin
         ext_select_ff     <= ext_select_in;
         ext_high_speed_ff <= ext_high_speed_in;
         ext_ack_ff        <= ext_ack_in;
         unlocked_ff       <= unlocked_in;
         clock_enables_ff  <= clock_enables_in;
         hint_bits_ff      <= hint_bits_in;
         hint_status_ff    <= hint_status_in;
      end
   end

endmodule

// ===== rtl/core/clock_manager_register_block.sv =====
// Register block for clock control: one request is one 4-byte bus access, and
// each request gives exactly one response, in order. A request is taken into an
// input register, decoded and applied to the registers as it moves into the
// response register, and a new request can be taken every cycle while the
// response side keeps up. Reads see every earlier write. A length other than
// 4 returns a burst error, a kind other than read or write a command error,
// and neither changes state.
module clock_manager_register_block
   import cmrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    rsp_free;
   logic    advance;
   logic    take;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign take      = req_valid && !req_stall;

   assign req_valid_in = take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   cmrb_csr u_csr (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
